[rtl/core/rne_pkg.sv]
package rne_pkg;

  // field widths
  localparam int ValueW  = 12;
  localparam int SymbolW = 7;

  // largest value that has a numeral
  localparam logic [ValueW-1:0] VALUE_MAX = 12'd3999;

  // ascii codes of the numeral letters
  localparam logic [SymbolW-1:0] CH_NONE = 7'h00;
  localparam logic [SymbolW-1:0] CH_I    = 7'h49;
  localparam logic [SymbolW-1:0] CH_V    = 7'h56;
  localparam logic [SymbolW-1:0] CH_X    = 7'h58;
  localparam logic [SymbolW-1:0] CH_L    = 7'h4C;
  localparam logic [SymbolW-1:0] CH_C    = 7'h43;
  localparam logic [SymbolW-1:0] CH_D    = 7'h44;
  localparam logic [SymbolW-1:0] CH_M    = 7'h4D;

  // one step of the greedy split: a weight and its one or two letters
  typedef struct packed {
    logic [ValueW-1:0]  weight;
    logic [SymbolW-1:0] first;
    logic [SymbolW-1:0] second;
    logic               dual;
  } rne_entry_t;

  localparam int Entries = 13;
  localparam int IdxW    = $clog2(Entries);

  // largest weight first, subtractive pairs in between
  localparam rne_entry_t RNE_STEPS [Entries] = '{
    '{12'd1000, CH_M, CH_NONE, 1'b0},
    '{12'd900,  CH_C, CH_M,    1'b1},
    '{12'd500,  CH_D, CH_NONE, 1'b0},
    '{12'd400,  CH_C, CH_D,    1'b1},
    '{12'd100,  CH_C, CH_NONE, 1'b0},
    '{12'd90,   CH_X, CH_C,    1'b1},
    '{12'd50,   CH_L, CH_NONE, 1'b0},
    '{12'd40,   CH_X, CH_L,    1'b1},
    '{12'd10,   CH_X, CH_NONE, 1'b0},
    '{12'd9,    CH_I, CH_X,    1'b1},
    '{12'd5,    CH_V, CH_NONE, 1'b0},
    '{12'd4,    CH_I, CH_V,    1'b1},
    '{12'd1,    CH_I, CH_NONE, 1'b0}
  };

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_ERR
  } rne_state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic step;
    logic fault;
  } rne_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic in_range;
    logic slot_free;
    logic last_char;
  } rne_status_t;

endpackage

[rtl/core/rne_if.sv]
interface rne_in_if import rne_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ValueW-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface rne_out_if import rne_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [SymbolW-1:0] symbol;
  logic               last;
  logic               range_error;

  modport source (output valid, output symbol, output last, output range_error, input ready);
  modport sink   (input valid, input symbol, input last, input range_error, output ready);
endinterface

[rtl/core/rne_ctrl.sv]
module rne_ctrl import rne_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  rne_status_t status,
  output rne_cmd_t    cmd
);

  rne_state_t state;
  rne_state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = status.in_range ? ST_RUN : ST_ERR;
        end
      end
      ST_RUN: begin
        if (status.slot_free && status.last_char) begin
          state_next = ST_IDLE;
        end
      end
      ST_ERR: begin
        if (status.slot_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    in_ready  = 1'b0;
    cmd       = '0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_RUN: begin
        cmd.step = status.slot_free;
      end
      ST_ERR: begin
        cmd.fault = status.slot_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

[rtl/core/rne_datapath.sv]
module rne_datapath import rne_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic [ValueW-1:0]  in_value,
  input  rne_cmd_t           cmd,
  output rne_status_t        status,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [SymbolW-1:0] out_symbol,
  output logic               out_last,
  output logic               out_error
);

  logic [ValueW-1:0]  remain;
  logic               pend;
  logic [SymbolW-1:0] pend_sym;

  logic [IdxW-1:0]    sel;
  rne_entry_t         entry;
  logic [ValueW-1:0]  remain_after;
  logic [SymbolW-1:0] emit_sym;
  logic               emit_last;

  // pick the largest weight that still fits in the remainder
  always_comb begin
    sel = '0;
    for (int i = Entries - 1; i >= 0; i--) begin
      if (remain >= RNE_STEPS[i].weight) begin
        sel = IdxW'(i);
      end
    end
  end

  assign entry        = RNE_STEPS[sel];
  assign remain_after = remain - entry.weight;

  // character for this cycle: held second letter first
  always_comb begin
    if (pend) begin
      emit_sym  = pend_sym;
      emit_last = (remain == '0);
    end else begin
      emit_sym  = entry.first;
      emit_last = !entry.dual && (remain_after == '0);
    end
  end

  assign status.in_range  = (in_value != '0) && (in_value <= VALUE_MAX);
  assign status.slot_free = !out_valid || out_ready;
  assign status.last_char = emit_last;

  // remainder and held second letter
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else if (cmd.load) begin
      remain <= in_value;
      pend   <= 1'b0;
    end else if (cmd.step) begin
      if (pend) begin
        pend <= 1'b0;
      end else begin
        remain   <= remain_after;
        pend     <= entry.dual;
        pend_sym <= entry.second;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.step) begin
      out_valid  <= 1'b1;
      out_symbol <= emit_sym;
      out_last   <= emit_last;
      out_error  <= 1'b0;
    end else if (cmd.fault) begin
      out_valid  <= 1'b1;
      out_symbol <= CH_NONE;
      out_last   <= 1'b1;
      out_error  <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

[rtl/core/roman_numeral_encoder.sv]
// Converts one unsigned 12-bit value per input item into its Roman numeral,
// sent as ASCII letters one per output item with last set on the final
// letter. Values 0 and above 3999 give a single item with symbol 0, last 1
// and range_error 1. The input is taken only while the block is idle. A
// numeral has at most 15 letters, for 3888. The letter sequencer walks a
// greedy subtraction table one letter per cycle, while the output sink
// accepts, into a single output register; a new value may be accepted
// while the final letter still waits in that register.
module roman_numeral_encoder import rne_pkg::*; (
  input logic       clk,
  input logic       rst,
  rne_in_if.sink    in_ch,
  rne_out_if.source out_ch
);

  rne_cmd_t    cmd;
  rne_status_t status;

  // sequencer
  rne_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // remainder, letter table and output register
  rne_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .in_value   (in_ch.value),
    .cmd        (cmd),
    .status     (status),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_symbol (out_ch.symbol),
    .out_last   (out_ch.last),
    .out_error  (out_ch.range_error)
  );

endmodule
